/* hdl/line_follow_drive_controller_assert.svh */
// Assertion macros shared by the controller RTL.
// Each macro checks on the rising clock edge and is off while rst_n is low.
`ifndef LINE_FOLLOW_DRIVE_CONTROLLER_ASSERT_SVH
`define LINE_FOLLOW_DRIVE_CONTROLLER_ASSERT_SVH

// Same-cycle implication: when cond holds, prop must hold too.
`define LFDC_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication: when cond holds, prop must hold in the next cycle.
`define LFDC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* hdl/lfdc_pkg.sv */
package lfdc_pkg;

  localparam int SENSOR_W = 10;
  localparam int SPEED_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int THR_W    = 12;
  localparam int DUTY_W   = 10;
  localparam int LOST_W   = 2;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  localparam int DUTY_MAX = 600;
  localparam logic [DUTY_W-1:0] DUTY_CAP  = DUTY_W'(DUTY_MAX);
  localparam logic [DUTY_W-1:0] DUTY_LOST = DUTY_W'(DUTY_MAX - 200);

  // Speed term limits in Q8.8, and the error above which the integral clears.
  localparam int SPD_MIN_Q       = -150 * 256;
  localparam int SPD_MAX_Q       = 500 * 256;
  localparam int INT_CLEAR_LIMIT = 50;

  // Lost-line state codes.
  localparam logic [LOST_W-1:0] LOST_NONE   = 2'd0;
  localparam logic [LOST_W-1:0] LOST_FIRST  = 2'd1;
  localparam logic [LOST_W-1:0] LOST_SECOND = 2'd2;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_TARGET_SPEED = 3'd0;
  localparam logic [2:0] REG_BASE_SPEED   = 3'd1;
  localparam logic [2:0] REG_SPEED_KP     = 3'd2;
  localparam logic [2:0] REG_SPEED_KI     = 3'd3;
  localparam logic [2:0] REG_DIR_KP       = 3'd4;
  localparam logic [2:0] REG_DIR_KD       = 3'd5;
  localparam logic [2:0] REG_LEFT_THR     = 3'd6;
  localparam logic [2:0] REG_RIGHT_THR    = 3'd7;

  // Register reset values.
  localparam logic [SENSOR_W-1:0] RST_TARGET_SPEED = 10'd120;
  localparam logic [SENSOR_W-1:0] RST_BASE_SPEED   = 10'd20;
  localparam logic [GAIN_W-1:0]   RST_SPEED_KP     = 16'd1280;
  localparam logic [GAIN_W-1:0]   RST_SPEED_KI     = 16'd26;
  localparam logic [GAIN_W-1:0]   RST_DIR_KP       = 16'd1280;
  localparam logic [GAIN_W-1:0]   RST_DIR_KD       = 16'd12800;
  localparam logic [THR_W-1:0]    RST_LEFT_THR     = 12'd0;
  localparam logic [THR_W-1:0]    RST_RIGHT_THR    = 12'd0;

endpackage

/* hdl/lfdc_if.sv */
interface lfdc_in_if;
  logic                                valid;
  logic                                ready;
  logic [lfdc_pkg::SENSOR_W-1:0]       sensor_a;
  logic [lfdc_pkg::SENSOR_W-1:0]       sensor_b;
  logic [lfdc_pkg::SENSOR_W-1:0]       sensor_c;
  logic [lfdc_pkg::SENSOR_W-1:0]       sensor_d;
  logic signed [lfdc_pkg::SPEED_W-1:0] measured_speed;

  modport source (output valid, sensor_a, sensor_b, sensor_c, sensor_d, measured_speed,
                  input ready);
  modport sink (input valid, sensor_a, sensor_b, sensor_c, sensor_d, measured_speed,
                output ready);
endinterface

interface lfdc_out_if;
  logic                        valid;
  logic                        ready;
  logic [lfdc_pkg::DUTY_W-1:0] duty_left;
  logic [lfdc_pkg::DUTY_W-1:0] duty_right;
  logic [lfdc_pkg::LOST_W-1:0] lost_state;

  modport source (output valid, duty_left, duty_right, lost_state, input ready);
  modport sink (input valid, duty_left, duty_right, lost_state, output ready);
endinterface

/* hdl/line_follow_drive_controller.sv */
// Path: each item passes the input, product and result registers in that order, and out_if.valid
// rises once the item sits in the result register.
// Throughput: one item per cycle while out_if.ready is high. A stage loads when empty or when
// its item moves on in the same cycle; with all three stages full, in_if.ready follows out_if.ready
// combinationally. Reset: synchronous, active-low rst_n; registers return to defaults, controller
// state clears to zero, all stages empty. No clearing pass is needed.
`include "line_follow_drive_controller_assert.svh"

module line_follow_drive_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  lfdc_in_if.sink                       in_if,
  lfdc_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfdc_pkg::CFG_AW-1:0]   paddr,
  input  logic [lfdc_pkg::CFG_DW-1:0]   pwdata,
  output logic [lfdc_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  // ------------------------------------------------------------------
  // Configuration registers. The APB port never waits, so a write lands
  // at the access cycle. The register index is the word address.
  // ------------------------------------------------------------------
  logic [lfdc_pkg::SENSOR_W-1:0] target_speed_r, base_speed_r;
  logic [lfdc_pkg::GAIN_W-1:0]   speed_kp_r, speed_ki_r, dir_kp_r, dir_kd_r;
  logic [lfdc_pkg::THR_W-1:0]    left_thr_r, right_thr_r;
  logic                          cfg_wr;
  logic [2:0]                    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_speed_r <= lfdc_pkg::RST_TARGET_SPEED;
      base_speed_r   <= lfdc_pkg::RST_BASE_SPEED;
      speed_kp_r     <= lfdc_pkg::RST_SPEED_KP;
      speed_ki_r     <= lfdc_pkg::RST_SPEED_KI;
      dir_kp_r       <= lfdc_pkg::RST_DIR_KP;
      dir_kd_r       <= lfdc_pkg::RST_DIR_KD;
      left_thr_r     <= lfdc_pkg::RST_LEFT_THR;
      right_thr_r    <= lfdc_pkg::RST_RIGHT_THR;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lfdc_pkg::REG_TARGET_SPEED: target_speed_r <= pwdata[lfdc_pkg::SENSOR_W-1:0];
        lfdc_pkg::REG_BASE_SPEED:   base_speed_r   <= pwdata[lfdc_pkg::SENSOR_W-1:0];
        lfdc_pkg::REG_SPEED_KP:     speed_kp_r     <= pwdata[lfdc_pkg::GAIN_W-1:0];
        lfdc_pkg::REG_SPEED_KI:     speed_ki_r     <= pwdata[lfdc_pkg::GAIN_W-1:0];
        lfdc_pkg::REG_DIR_KP:       dir_kp_r       <= pwdata[lfdc_pkg::GAIN_W-1:0];
        lfdc_pkg::REG_DIR_KD:       dir_kd_r       <= pwdata[lfdc_pkg::GAIN_W-1:0];
        lfdc_pkg::REG_LEFT_THR:     left_thr_r     <= pwdata[lfdc_pkg::THR_W-1:0];
        lfdc_pkg::REG_RIGHT_THR:    right_thr_r    <= pwdata[lfdc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      lfdc_pkg::REG_TARGET_SPEED: prdata = lfdc_pkg::CFG_DW'(target_speed_r);
      lfdc_pkg::REG_BASE_SPEED:   prdata = lfdc_pkg::CFG_DW'(base_speed_r);
      lfdc_pkg::REG_SPEED_KP:     prdata = lfdc_pkg::CFG_DW'(speed_kp_r);
      lfdc_pkg::REG_SPEED_KI:     prdata = lfdc_pkg::CFG_DW'(speed_ki_r);
      lfdc_pkg::REG_DIR_KP:       prdata = lfdc_pkg::CFG_DW'(dir_kp_r);
      lfdc_pkg::REG_DIR_KD:       prdata = lfdc_pkg::CFG_DW'(dir_kd_r);
      lfdc_pkg::REG_LEFT_THR:     prdata = lfdc_pkg::CFG_DW'(left_thr_r);
      lfdc_pkg::REG_RIGHT_THR:    prdata = lfdc_pkg::CFG_DW'(right_thr_r);
      default:                    prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Stage handshake. Each stage takes a new item when it is empty or when
  // its item moves on in the same cycle, so bubbles collapse under stall.
  // ------------------------------------------------------------------
  logic v1_r, v2_r, v3_r;
  logic ready1, ready2, ready3;
  logic load1, move12, move23;

  assign ready3      = !v3_r || out_if.ready;
  assign ready2      = !v2_r || ready3;
  assign ready1      = !v1_r || ready2;
  assign in_if.ready = ready1;
  assign load1       = in_if.valid && ready1;
  assign move12      = v1_r && ready2;
  assign move23      = v2_r && ready3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= in_if.valid;
      if (ready2) v2_r <= v1_r;
      if (ready3) v3_r <= v2_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: input register.
  // ------------------------------------------------------------------
  logic [lfdc_pkg::SENSOR_W-1:0]       s1_a_r, s1_b_r, s1_c_r, s1_d_r;
  logic signed [lfdc_pkg::SPEED_W-1:0] s1_ms_r;

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_a_r  <= in_if.sensor_a;
      s1_b_r  <= in_if.sensor_b;
      s1_c_r  <= in_if.sensor_c;
      s1_d_r  <= in_if.sensor_d;
      s1_ms_r <= in_if.measured_speed;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: position error, lost-line tracking, integral update and the
  // four gain products. The controller state advances here, one item at a
  // time in order, so the next item always sees this item's state.
  // ------------------------------------------------------------------
  logic signed [12:0] position_last_r, hist0_r, hist1_r;
  logic signed [31:0] integral_r, integral_nxt;
  logic [lfdc_pkg::LOST_W-1:0] lost_r, lost_nxt;

  logic signed [12:0] pos;
  logic signed [13:0] pos_diff;
  logic signed [14:0] pos_total;
  logic [11:0]        sensor_sum;
  logic               over_l, over_r;
  logic signed [16:0] err;
  logic signed [32:0] integral_sum;
  logic signed [31:0] integral_sat;

  logic signed [29:0] p_dir_kp, s2_dir_kp_r;
  logic signed [30:0] p_dir_kd, s2_dir_kd_r;
  logic signed [33:0] p_spd_kp, s2_spd_kp_r;
  logic signed [48:0] p_spd_ki, s2_spd_ki_r;
  logic [lfdc_pkg::LOST_W-1:0] s2_lost_r;

  always_comb begin
    pos = $signed({3'b000, s1_a_r}) - $signed({3'b000, s1_d_r})
        + $signed({3'b000, s1_b_r}) - $signed({3'b000, s1_c_r});
    pos_diff   = 14'(pos) - 14'(position_last_r);
    pos_total  = 15'(pos) + 15'(hist0_r) + 15'(hist1_r);
    sensor_sum = 12'(s1_a_r) + 12'(s1_b_r) + 12'(s1_c_r) + 12'(s1_d_r);
    over_l     = left_thr_r < sensor_sum;
    over_r     = right_thr_r < sensor_sum;

    // The line is lost first toward one side, then toward the other; it is
    // found again only once the sensor sum exceeds neither threshold.
    lost_nxt = lost_r;
    if (over_l || over_r) begin
      if (pos_total > 15'sd0 && lost_r == lfdc_pkg::LOST_NONE && over_l) begin
        lost_nxt = lfdc_pkg::LOST_FIRST;
      end else if (pos_total < 15'sd0 && lost_r == lfdc_pkg::LOST_FIRST && over_r) begin
        lost_nxt = lfdc_pkg::LOST_SECOND;
      end
    end else begin
      lost_nxt = lfdc_pkg::LOST_NONE;
    end

    err = $signed({7'b0, target_speed_r}) - 17'(s1_ms_r);

    // The integral saturates at the 32-bit limits and clears when err is above INT_CLEAR_LIMIT.
    integral_sum = 33'(integral_r) + 33'(err);
    if (integral_sum[32] != integral_sum[31]) begin
      integral_sat = integral_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      integral_sat = integral_sum[31:0];
    end
    integral_nxt = (err > 17'(lfdc_pkg::INT_CLEAR_LIMIT)) ? 32'sd0 : integral_sat;

    // The speed products use the integral from before this item.
    p_dir_kp = $signed({1'b0, dir_kp_r}) * pos;
    p_dir_kd = $signed({1'b0, dir_kd_r}) * pos_diff;
    p_spd_kp = $signed({1'b0, speed_kp_r}) * err;
    p_spd_ki = $signed({1'b0, speed_ki_r}) * integral_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_last_r <= '0;
      hist0_r         <= '0;
      hist1_r         <= '0;
      integral_r      <= '0;
      lost_r          <= lfdc_pkg::LOST_NONE;
    end else if (move12) begin
      position_last_r <= pos;
      hist0_r         <= pos;
      hist1_r         <= hist0_r;
      integral_r      <= integral_nxt;
      lost_r          <= lost_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move12) begin
      s2_dir_kp_r <= p_dir_kp;
      s2_dir_kd_r <= p_dir_kd;
      s2_spd_kp_r <= p_spd_kp;
      s2_spd_ki_r <= p_spd_ki;
      s2_lost_r   <= lost_nxt;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: sum the terms, clamp the speed term, mix in Q8.8, clamp each
  // duty to [0, DUTY_MAX], drop the fraction and apply the lost-line
  // override. The zero floor of the inner wheel falls out of the clamp.
  // ------------------------------------------------------------------
  function automatic logic [lfdc_pkg::DUTY_W-1:0] duty_q(input logic signed [32:0] q);
    logic [lfdc_pkg::DUTY_W-1:0] d;
    if (q < 33'sd0) begin
      d = '0;
    end else if (q > 33'(lfdc_pkg::DUTY_MAX * 256)) begin
      d = lfdc_pkg::DUTY_CAP;
    end else begin
      d = q[17:8];
    end
    return d;
  endfunction

  logic signed [31:0] steer;
  logic signed [49:0] spd_raw;
  logic signed [18:0] spd;
  logic signed [19:0] common;
  logic signed [32:0] q_left, q_right;
  logic [lfdc_pkg::DUTY_W-1:0] duty_l, duty_r;

  always_comb begin
    steer   = 32'(s2_dir_kp_r) + 32'(s2_dir_kd_r);
    spd_raw = 50'(s2_spd_kp_r) + 50'(s2_spd_ki_r);
    if (spd_raw < 50'(lfdc_pkg::SPD_MIN_Q)) begin
      spd = 19'(lfdc_pkg::SPD_MIN_Q);
    end else if (spd_raw > 50'(lfdc_pkg::SPD_MAX_Q)) begin
      spd = 19'(lfdc_pkg::SPD_MAX_Q);
    end else begin
      spd = spd_raw[18:0];
    end
    common  = $signed({2'b00, base_speed_r, 8'h00}) + 20'(spd);
    q_left  = 33'(common) + 33'(steer);
    q_right = 33'(common) - 33'(steer);

    case (s2_lost_r)
      lfdc_pkg::LOST_FIRST: begin
        duty_l = '0;
        duty_r = lfdc_pkg::DUTY_LOST;
      end
      lfdc_pkg::LOST_SECOND: begin
        duty_l = lfdc_pkg::DUTY_LOST;
        duty_r = '0;
      end
      default: begin
        duty_l = duty_q(q_left);
        duty_r = duty_q(q_right);
      end
    endcase
  end

  logic [lfdc_pkg::DUTY_W-1:0] duty_left_r, duty_right_r;
  logic [lfdc_pkg::LOST_W-1:0] lost_state_r;

  always_ff @(posedge clk) begin
    if (move23) begin
      duty_left_r  <= duty_l;
      duty_right_r <= duty_r;
      lost_state_r <= s2_lost_r;
    end
  end

  assign out_if.valid      = v3_r;
  assign out_if.duty_left  = duty_left_r;
  assign out_if.duty_right = duty_right_r;
  assign out_if.lost_state = lost_state_r;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  `LFDC_ASSERT_NOW(a_duty_cap, out_if.valid, (out_if.duty_left <= lfdc_pkg::DUTY_CAP) && (out_if.duty_right <= lfdc_pkg::DUTY_CAP), "duty above DUTY_MAX")
  `LFDC_ASSERT_NOW(a_lost_override, out_if.valid && out_if.lost_state == lfdc_pkg::LOST_FIRST, out_if.duty_left == '0 && out_if.duty_right == lfdc_pkg::DUTY_LOST, "lost-line override not applied")
  `LFDC_ASSERT_NEXT(a_integral_clear, move12 && (err > 17'(lfdc_pkg::INT_CLEAR_LIMIT)), integral_r == 32'sd0, "integral not cleared on large error")
  `LFDC_ASSERT_NEXT(a_lost_order, lost_r == lfdc_pkg::LOST_SECOND, lost_r != lfdc_pkg::LOST_FIRST, "lost state stepped back from second to first")

endmodule
